@@ rtl/cmpf_pkg.sv @@
package cmpf_pkg;

    // Fixed-point angle constants, 2^-16 degree
    localparam logic signed [25:0] ANG_90  = 26'sd5898240;
    localparam logic signed [25:0] ANG_180 = 26'sd11796480;

    // Datapath step counts
    localparam int ROOT_STEPS = 25;
    localparam int DIV_STEPS  = 53;
    localparam logic [25:0] MS_PER_S = 26'd1000;

    typedef struct packed {
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic        [15:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] tilt_angle;
    } out_item_t;

    typedef struct packed {
        logic        [15:0] blend_alpha;
        logic signed [15:0] accel_bias_x;
        logic signed [15:0] accel_bias_y;
        logic signed [15:0] accel_bias_z;
        logic signed [15:0] gyro_bias_x;
        logic signed [15:0] gyro_bias_y;
        logic        [15:0] gyro_counts_per_dps_x16;
    } cfg_regs_t;

    localparam logic [15:0] ALPHA_RESET  = 16'd64225;
    localparam logic [15:0] COUNTS_RESET = 16'd2096;

    typedef enum logic [2:0] {
        CFG_ALPHA   = 3'd0,
        CFG_ABIAS_X = 3'd1,
        CFG_ABIAS_Y = 3'd2,
        CFG_ABIAS_Z = 3'd3,
        CFG_GBIAS_X = 3'd4,
        CFG_GBIAS_Y = 3'd5,
        CFG_COUNTS  = 3'd6
    } cfg_index_t;

    // Bias-corrected sample handed from front to back
    typedef struct packed {
        logic signed [16:0] ax;
        logic signed [16:0] ay;
        logic signed [16:0] az;
        logic        [15:0] gx_mag;
        logic               gx_neg;
        logic        [15:0] gy_mag;
        logic               gy_neg;
        logic        [15:0] ms;
    } work_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_SETUP,
        S_ROOT,
        S_CLOAD,
        S_CORDIC,
        S_WAIT,
        S_PROP,
        S_MUL,
        S_DONE
    } back_state_t;

    // Arctangent of 2^-i in 2^-16 degree
    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // Clamp to +-180 degrees
    function automatic logic signed [25:0] sat180(input logic signed [54:0] v);
        logic signed [25:0] r;
        if (v > 55'(ANG_180)) begin
            r = ANG_180;
        end
        else if (v < -55'(ANG_180)) begin
            r = -ANG_180;
        end
        else begin
            r = v[25:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/cmpf_fifo.sv @@
module cmpf_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cmpf_pkg::work_t    push_data,
    input  logic               pop,
    output cmpf_pkg::work_t    pop_data,
    output logic               full,
    output logic               empty
);

    cmpf_pkg::work_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Store a beat at the write pointer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/cmpf_front.sv @@
module cmpf_front (
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cmpf_pkg::in_item_t   in_data,
    input  cmpf_pkg::cfg_regs_t  cfg,
    input  logic                 q_full,
    output logic                 q_push,
    output cmpf_pkg::work_t      q_data
);

    logic signed [16:0] gx;
    logic signed [16:0] gy;
    logic signed [16:0] gx_abs;
    logic signed [16:0] gy_abs;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Remove offsets and split gyro into sign and magnitude
    always_comb
    begin
        gx     = 17'(in_data.rate_x) - 17'(cfg.gyro_bias_x);
        gy     = 17'(in_data.rate_y) - 17'(cfg.gyro_bias_y);
        gx_abs = gx[16] ? -gx : gx;
        gy_abs = gy[16] ? -gy : gy;

        q_data.ax     = 17'(in_data.acc_x) - 17'(cfg.accel_bias_x);
        q_data.ay     = 17'(in_data.acc_y) - 17'(cfg.accel_bias_y);
        q_data.az     = 17'(in_data.acc_z) - 17'(cfg.accel_bias_z);
        q_data.gx_mag = gx_abs[15:0];
        q_data.gx_neg = gx[16];
        q_data.gy_mag = gy_abs[15:0];
        q_data.gy_neg = gy[16];
        q_data.ms     = in_data.elapsed_ms;
    end

endmodule

@@ rtl/cmpf_back.sv @@
module cmpf_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmpf_pkg::cfg_regs_t  cfg,
    input  logic                 q_empty,
    input  cmpf_pkg::work_t      q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cmpf_pkg::out_item_t  out_data
);

    localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    cmpf_pkg::back_state_t state_reg;
    cmpf_pkg::back_state_t state_next;

    cmpf_pkg::work_t       item_reg;
    logic [5:0]            step_cnt_reg;
    logic [5:0]            div_cnt_reg;

    // squares and gyro products
    logic [31:0]           sq_reg [3];
    logic [31:0]           gp_reg [2];
    logic [25:0]           den_reg;

    // square-root lanes: xz, yz, xy
    logic [49:0]           rad_reg  [3];
    logic [24:0]           root_reg [3];
    logic [26:0]           srem_reg [3];

    // divider lanes: roll gyro, pitch gyro
    logic [52:0]           dnum_reg [2];
    logic [25:0]           drem_reg [2];

    // CORDIC lanes: roll, pitch, tilt
    logic signed [27:0]    cx_reg [3];
    logic signed [27:0]    cy_reg [3];
    logic signed [25:0]    cz_reg [3];
    logic                  hold_reg [3];

    logic signed [25:0]    pr_reg;
    logic signed [25:0]    pp_reg;
    logic signed [43:0]    prod_reg [3];
    logic signed [25:0]    base_reg [3];

    logic signed [31:0]    roll_est_reg;
    logic signed [31:0]    pitch_est_reg;
    logic signed [31:0]    tilt_est_reg;

    logic                  out_valid_reg;
    cmpf_pkg::out_item_t   out_data_reg;

    logic signed [33:0]    sq_full [3];
    logic [15:0]           counts_eff;
    logic [25:0]           den_full;
    logic [32:0]           sum_full [3];
    logic [28:0]           s_rem2 [3];
    logic [28:0]           s_trial [3];
    logic [26:0]           d_rem2 [2];
    logic signed [27:0]    ld_x [3];
    logic signed [27:0]    ld_y [3];
    logic signed [24:0]    ay_sc;
    logic signed [24:0]    ax_sc;
    logic [15:0]           az_abs;
    logic signed [16:0]    az_neg_v;
    logic signed [27:0]    dxs [3];
    logic signed [27:0]    dys [3];
    logic signed [25:0]    tabv;
    logic signed [53:0]    delta [2];
    logic signed [25:0]    blend_a [3];
    logic signed [26:0]    diff [3];
    logic signed [54:0]    blended [3];
    logic signed [25:0]    new_est [3];
    logic signed [26:0]    rnd [3];
    logic                  out_load;

    assign q_pop     = (state_reg == cmpf_pkg::S_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = (state_reg == cmpf_pkg::S_DONE) && (!out_valid_reg || !out_stall);

    // Sequence one sample through the datapath
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmpf_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = cmpf_pkg::S_SQUARE;
                end
            end
            cmpf_pkg::S_SQUARE: state_next = cmpf_pkg::S_SETUP;
            cmpf_pkg::S_SETUP:  state_next = cmpf_pkg::S_ROOT;
            cmpf_pkg::S_ROOT:
            begin
                if (step_cnt_reg == 6'(cmpf_pkg::ROOT_STEPS - 1))
                begin
                    state_next = cmpf_pkg::S_CLOAD;
                end
            end
            cmpf_pkg::S_CLOAD:  state_next = cmpf_pkg::S_CORDIC;
            cmpf_pkg::S_CORDIC:
            begin
                if (step_cnt_reg == 6'(NSTEP - 1))
                begin
                    state_next = cmpf_pkg::S_WAIT;
                end
            end
            cmpf_pkg::S_WAIT:
            begin
                if (div_cnt_reg == 6'd0)
                begin
                    state_next = cmpf_pkg::S_PROP;
                end
            end
            cmpf_pkg::S_PROP:   state_next = cmpf_pkg::S_MUL;
            cmpf_pkg::S_MUL:    state_next = cmpf_pkg::S_DONE;
            cmpf_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = cmpf_pkg::S_IDLE;
                end
            end
            default:            state_next = cmpf_pkg::S_IDLE;
        endcase
    end

    // Per-lane combinational arithmetic
    always_comb
    begin
        sq_full[0] = item_reg.ax * item_reg.ax;
        sq_full[1] = item_reg.ay * item_reg.ay;
        sq_full[2] = item_reg.az * item_reg.az;
        counts_eff = (cfg.gyro_counts_per_dps_x16 == 16'd0) ? 16'd1
                                                            : cfg.gyro_counts_per_dps_x16;
        den_full   = 26'(counts_eff) * cmpf_pkg::MS_PER_S;

        sum_full[0] = {1'b0, sq_reg[0]} + {1'b0, sq_reg[2]};
        sum_full[1] = {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
        sum_full[2] = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};

        for (int l = 0; l < 3; l++)
        begin
            s_rem2[l]  = {srem_reg[l], rad_reg[l][49:48]};
            s_trial[l] = {2'b00, root_reg[l], 2'b01};
        end
        for (int l = 0; l < 2; l++)
        begin
            d_rem2[l] = {drem_reg[l], dnum_reg[l][52]};
        end

        // CORDIC start vectors
        ay_sc    = {item_reg.ay, 8'h00};
        ax_sc    = {item_reg.ax, 8'h00};
        az_neg_v = -item_reg.az;
        az_abs   = item_reg.az[16] ? az_neg_v[15:0] : item_reg.az[15:0];
        ld_y[0]  = 28'(ay_sc);
        ld_x[0]  = {3'b000, root_reg[0]};
        ld_y[1]  = 28'(ax_sc);
        ld_x[1]  = {3'b000, root_reg[1]};
        ld_x[2]  = {4'h0, az_abs, 8'h00};
        ld_y[2]  = item_reg.az[16] ? -{3'b000, root_reg[2]} : {3'b000, root_reg[2]};

        tabv = {4'h0, cmpf_pkg::atan_entry(step_cnt_reg[4:0])};
        for (int l = 0; l < 3; l++)
        begin
            dxs[l] = cy_reg[l] >>> step_cnt_reg[4:0];
            dys[l] = cx_reg[l] >>> step_cnt_reg[4:0];
        end

        delta[0] = item_reg.gx_neg ? -{1'b0, dnum_reg[0]} : {1'b0, dnum_reg[0]};
        delta[1] = item_reg.gy_neg ? -{1'b0, dnum_reg[1]} : {1'b0, dnum_reg[1]};

        // Blend towards the gyro path by alpha: b + alpha * (a - b)
        blend_a[0] = pr_reg;
        blend_a[1] = pp_reg;
        blend_a[2] = tilt_est_reg[25:0];
        for (int l = 0; l < 3; l++)
        begin
            diff[l]    = 27'(blend_a[l]) - 27'(cz_reg[l]);
            blended[l] = 55'(base_reg[l]) + 55'((prod_reg[l] + 44'sd32768) >>> 16);
            new_est[l] = cmpf_pkg::sat180(blended[l]);
            rnd[l]     = (27'(new_est[l]) + 27'sd256) >>> 9;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_data;
        end

        if (state_reg == cmpf_pkg::S_SQUARE)
        begin
            for (int l = 0; l < 3; l++)
            begin
                sq_reg[l] <= sq_full[l][31:0];
            end
            gp_reg[0] <= 32'(item_reg.gx_mag) * 32'(item_reg.ms);
            gp_reg[1] <= 32'(item_reg.gy_mag) * 32'(item_reg.ms);
            den_reg   <= den_full;
        end

        // Load roots and dividers
        if (state_reg == cmpf_pkg::S_SETUP)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rad_reg[l]  <= {1'b0, sum_full[l], 16'h0000};
                root_reg[l] <= 25'd0;
                srem_reg[l] <= 27'd0;
            end
            for (int l = 0; l < 2; l++)
            begin
                dnum_reg[l] <= {1'b0, gp_reg[l], 20'h00000} + 53'(den_reg[25:1]);
                drem_reg[l] <= 26'd0;
            end
        end

        // One root digit per cycle
        if (state_reg == cmpf_pkg::S_ROOT)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rad_reg[l] <= {rad_reg[l][47:0], 2'b00};
                if (s_rem2[l] >= s_trial[l])
                begin
                    srem_reg[l] <= 27'(s_rem2[l] - s_trial[l]);
                    root_reg[l] <= {root_reg[l][23:0], 1'b1};
                end
                else
                begin
                    srem_reg[l] <= s_rem2[l][26:0];
                    root_reg[l] <= {root_reg[l][23:0], 1'b0};
                end
            end
        end

        // One quotient bit per cycle
        if (div_cnt_reg != 6'd0)
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (d_rem2[l] >= {1'b0, den_reg})
                begin
                    drem_reg[l] <= 26'(d_rem2[l] - {1'b0, den_reg});
                    dnum_reg[l] <= {dnum_reg[l][51:0], 1'b1};
                end
                else
                begin
                    drem_reg[l] <= d_rem2[l][25:0];
                    dnum_reg[l] <= {dnum_reg[l][51:0], 1'b0};
                end
            end
        end

        // Start vectors, with axis cases settled at once
        if (state_reg == cmpf_pkg::S_CLOAD)
        begin
            for (int l = 0; l < 3; l++)
            begin
                cx_reg[l] <= ld_x[l];
                cy_reg[l] <= ld_y[l];
                if (ld_x[l] == 28'sd0)
                begin
                    hold_reg[l] <= 1'b1;
                    if (ld_y[l] > 28'sd0)
                    begin
                        cz_reg[l] <= cmpf_pkg::ANG_90;
                    end
                    else if (ld_y[l] < 28'sd0)
                    begin
                        cz_reg[l] <= -cmpf_pkg::ANG_90;
                    end
                    else
                    begin
                        cz_reg[l] <= 26'sd0;
                    end
                end
                else
                begin
                    hold_reg[l] <= (ld_y[l] == 28'sd0);
                    cz_reg[l]   <= 26'sd0;
                end
            end
        end

        // Vectoring rotation
        if (state_reg == cmpf_pkg::S_CORDIC)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (!hold_reg[l])
                begin
                    if (!cy_reg[l][27])
                    begin
                        cx_reg[l] <= cx_reg[l] + dxs[l];
                        cy_reg[l] <= cy_reg[l] - dys[l];
                        cz_reg[l] <= cz_reg[l] + tabv;
                    end
                    else
                    begin
                        cx_reg[l] <= cx_reg[l] - dxs[l];
                        cy_reg[l] <= cy_reg[l] + dys[l];
                        cz_reg[l] <= cz_reg[l] - tabv;
                    end
                end
            end
        end

        // Propagate by gyro
        if (state_reg == cmpf_pkg::S_PROP)
        begin
            pr_reg <= cmpf_pkg::sat180(55'(roll_est_reg) + 55'(delta[0]));
            pp_reg <= cmpf_pkg::sat180(55'(pitch_est_reg) + 55'(delta[1]));
        end

        if (state_reg == cmpf_pkg::S_MUL)
        begin
            for (int l = 0; l < 3; l++)
            begin
                prod_reg[l] <= $signed({1'b0, cfg.blend_alpha}) * diff[l];
                base_reg[l] <= cz_reg[l];
            end
        end

        if (out_load)
        begin
            out_data_reg.roll_angle  <= rnd[0][15:0];
            out_data_reg.pitch_angle <= rnd[1][15:0];
            out_data_reg.tilt_angle  <= rnd[2][15:0];
        end
    end

    // Control state and estimates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmpf_pkg::S_IDLE;
            step_cnt_reg  <= 6'd0;
            div_cnt_reg   <= 6'd0;
            out_valid_reg <= 1'b0;
            roll_est_reg  <= 32'sd0;
            pitch_est_reg <= 32'sd0;
            tilt_est_reg  <= 32'sd0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_next != state_reg)
            begin
                step_cnt_reg <= 6'd0;
            end
            else
            begin
                step_cnt_reg <= step_cnt_reg + 6'd1;
            end

            if (state_reg == cmpf_pkg::S_SETUP)
            begin
                div_cnt_reg <= 6'(cmpf_pkg::DIV_STEPS);
            end
            else if (div_cnt_reg != 6'd0)
            begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                roll_est_reg  <= 32'(new_est[0]);
                pitch_est_reg <= 32'(new_est[1]);
                tilt_est_reg  <= 32'(new_est[2]);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/imu_complementary_tilt_filter.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_data   (raw accel x/y/z, gyro x/y, elapsed ms)
// out       out_valid / out_stall  out_data  (roll, pitch, tilt in 1/128 degree)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Once a sample leaves the queue, the 53-step bit-serial gyro divider runs while the square
// roots and CORDIC run beside it; the result beat follows once all of them are done.
// Reset clears the estimates and loads the register defaults; no clearing pass.
// A two-beat queue lets the input side keep taking samples while the back end works,
// and the result register lets the next sample start while a result waits on out_stall.
module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cmpf_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cmpf_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    cmpf_pkg::cfg_regs_t cfg_reg;
    cmpf_pkg::work_t     push_data;
    cmpf_pkg::work_t     pop_data;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;

    assign cfg_ready = 1'b1;

    // Write configuration registers by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_alpha             <= cmpf_pkg::ALPHA_RESET;
            cfg_reg.accel_bias_x            <= 16'sd0;
            cfg_reg.accel_bias_y            <= 16'sd0;
            cfg_reg.accel_bias_z            <= 16'sd0;
            cfg_reg.gyro_bias_x             <= 16'sd0;
            cfg_reg.gyro_bias_y             <= 16'sd0;
            cfg_reg.gyro_counts_per_dps_x16 <= cmpf_pkg::COUNTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cmpf_pkg::cfg_index_t'(cfg_index))
                cmpf_pkg::CFG_ALPHA:   cfg_reg.blend_alpha             <= cfg_data;
                cmpf_pkg::CFG_ABIAS_X: cfg_reg.accel_bias_x            <= cfg_data;
                cmpf_pkg::CFG_ABIAS_Y: cfg_reg.accel_bias_y            <= cfg_data;
                cmpf_pkg::CFG_ABIAS_Z: cfg_reg.accel_bias_z            <= cfg_data;
                cmpf_pkg::CFG_GBIAS_X: cfg_reg.gyro_bias_x             <= cfg_data;
                cmpf_pkg::CFG_GBIAS_Y: cfg_reg.gyro_bias_y             <= cfg_data;
                cmpf_pkg::CFG_COUNTS:  cfg_reg.gyro_counts_per_dps_x16 <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cmpf_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    cmpf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    cmpf_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int DRAIN_CYCLES = 200;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    cmpf_pkg::in_item_t    in_data;
    logic                  out_valid;
    logic                  out_stall;
    cmpf_pkg::out_item_t   out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_index;
    logic [15:0]           cfg_data;

    // Predictor copy of registers and estimates
    logic [15:0]        p_alpha;
    logic signed [15:0] p_abx, p_aby, p_abz, p_gbx, p_gby;
    logic [15:0]        p_counts;
    longint             est_roll, est_pitch, est_tilt;

    cmpf_pkg::out_item_t angle_queue[$];
    int        fail_count;
    int        beats_checked;
    int        send_idle_pct;
    int        stall_pct;

    imu_complementary_tilt_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Floor shift right for signed values
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(input longint n);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint atan_step(input int i);
        longint tab[32];
        tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115,
                57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        return tab[i];
    endfunction

    // Vectoring arctangent of y/x in 2^-16 degree, x >= 0
    function automatic longint vector_atan(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0)
            return (y > 0) ? 90 * 65536 : ((y < 0) ? -90 * 65536 : 0);
        if (y == 0)
            return 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint clamp180(input longint v);
        if (v > 180 * 65536)
            return 180 * 65536;
        if (v < -180 * 65536)
            return -180 * 65536;
        return v;
    endfunction

    function automatic longint mix_angles(input longint a, input longint b);
        longint w;
        w = longint'(p_alpha);
        return floor_shr(w * a + (65536 - w) * b + 32768, 16);
    endfunction

    function automatic longint rate_step(input longint rate, input longint ms);
        longint den;
        longint mag;
        longint q;
        den = ((p_counts == 0) ? 1 : longint'(p_counts)) * 1000;
        mag = (rate < 0) ? -rate : rate;
        q = (mag * ms * 16 * 65536 + den / 2) / den;
        return (rate < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] to_out(input longint e);
        longint r;
        r = floor_shr(e + 256, 9);
        return r[15:0];
    endfunction

    // Advance the estimates by one sample and queue the expected angles
    task automatic predict_angles(input cmpf_pkg::in_item_t s);
        longint ax, ay, az, gx, gy;
        longint r_xz, r_yz, r_xy;
        longint a_roll, a_pitch, a_tilt, pr, pp;
        cmpf_pkg::out_item_t e;
        ax = longint'(s.acc_x) - longint'(p_abx);
        ay = longint'(s.acc_y) - longint'(p_aby);
        az = longint'(s.acc_z) - longint'(p_abz);
        gx = longint'(s.rate_x) - longint'(p_gbx);
        gy = longint'(s.rate_y) - longint'(p_gby);
        r_xz = int_sqrt((ax * ax + az * az) << 16);
        r_yz = int_sqrt((ay * ay + az * az) << 16);
        r_xy = int_sqrt((ax * ax + ay * ay) << 16);
        a_roll = vector_atan(ay * 256, r_xz);
        a_pitch = vector_atan(ax * 256, r_yz);
        a_tilt = (az >= 0) ? vector_atan(r_xy, az * 256) : vector_atan(-r_xy, -az * 256);
        pr = clamp180(est_roll + rate_step(gx, longint'(s.elapsed_ms)));
        pp = clamp180(est_pitch + rate_step(gy, longint'(s.elapsed_ms)));
        est_roll = clamp180(mix_angles(pr, a_roll));
        est_pitch = clamp180(mix_angles(pp, a_pitch));
        est_tilt = clamp180(mix_angles(est_tilt, a_tilt));
        e.roll_angle = to_out(est_roll);
        e.pitch_angle = to_out(est_pitch);
        e.tilt_angle = to_out(est_tilt);
        angle_queue.push_back(e);
    endtask

    // Send one sample beat, idling first at the current rate; valid drops on idle
    task automatic send_sample(input cmpf_pkg::in_item_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_angles(s);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (angle_queue.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input cmpf_pkg::cfg_index_t idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            cmpf_pkg::CFG_ALPHA:   p_alpha = v;
            cmpf_pkg::CFG_ABIAS_X: p_abx = v;
            cmpf_pkg::CFG_ABIAS_Y: p_aby = v;
            cmpf_pkg::CFG_ABIAS_Z: p_abz = v;
            cmpf_pkg::CFG_GBIAS_X: p_gbx = v;
            cmpf_pkg::CFG_GBIAS_Y: p_gby = v;
            cmpf_pkg::CFG_COUNTS:  p_counts = v;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic cmpf_pkg::in_item_t make_sample(input logic [15:0] ax,
                                                       input logic [15:0] ay,
                                                       input logic [15:0] az,
                                                       input logic [15:0] gx,
                                                       input logic [15:0] gy,
                                                       input logic [15:0] ms);
        cmpf_pkg::in_item_t s;
        s.acc_x = ax;
        s.acc_y = ay;
        s.acc_z = az;
        s.rate_x = gx;
        s.rate_y = gy;
        s.elapsed_ms = ms;
        return s;
    endfunction

    function automatic cmpf_pkg::in_item_t random_sample();
        cmpf_pkg::in_item_t s;
        s[31:0] = $urandom;
        s[95:64] = $urandom;
        s[63:32] = $urandom;
        // Mostly small steps and near-level readings, some raw noise
        if ($urandom_range(3) != 0)
        begin
            s.elapsed_ms = 16'($urandom_range(20));
            s.acc_z = 16'(16384 + $signed(16'($urandom_range(4000))) - 2000);
        end
        return s;
    endfunction

    // Zero, extreme and sign-boundary samples
    task automatic test_directed_extremes();
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(make_sample(0, 16'h7FFF, 0, 0, 0, 10));
        send_sample(make_sample(0, 16'h8000, 0, 0, 0, 10));
        send_sample(make_sample(16'h7FFF, 0, 0, 0, 0, 10));
        send_sample(make_sample(16'h8000, 0, 0, 0, 0, 10));
        send_sample(make_sample(0, 0, 16'h7FFF, 0, 0, 10));
        send_sample(make_sample(0, 0, 16'h8000, 0, 0, 10));
        send_sample(make_sample(100, 100, 16'hFF00, 0, 0, 1));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
        send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(make_sample(0, 0, 16384, 16'h7FFF, 16'h8000, 16'hFFFF));
        send_sample(make_sample(0, 0, 16384, 16'h7FFF, 16'h8000, 16'hFFFF));
        send_sample(make_sample(5, 16'hFFFB, 16384, 1, 16'hFFFF, 1));
        wait_idle();
    endtask

    // Registers at extremes, including zero sensitivity and biases
    task automatic test_register_extremes();
        write_reg(cmpf_pkg::CFG_ALPHA, 16'd0);
        write_reg(cmpf_pkg::CFG_COUNTS, 16'd0);
        write_reg(cmpf_pkg::CFG_ABIAS_X, 16'h7FFF);
        write_reg(cmpf_pkg::CFG_ABIAS_Y, 16'h8000);
        write_reg(cmpf_pkg::CFG_ABIAS_Z, 16'h8000);
        write_reg(cmpf_pkg::CFG_GBIAS_X, 16'h7FFF);
        write_reg(cmpf_pkg::CFG_GBIAS_Y, 16'h8000);
        for (int i = 0; i < 4; i++)
            send_sample(random_sample());
        wait_idle();
        write_reg(cmpf_pkg::CFG_ALPHA, 16'hFFFF);
        write_reg(cmpf_pkg::CFG_COUNTS, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            send_sample(random_sample());
        send_sample(make_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 0));
        wait_idle();
    endtask

    // Random samples across idling phases and register settings
    task automatic test_random_phases();
        int idle_set[4][2];
        idle_set = '{'{0, 0}, '{70, 0}, '{0, 70}, '{30, 30}};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(cmpf_pkg::CFG_ALPHA, 16'($urandom_range(65535)));
            write_reg(cmpf_pkg::CFG_ABIAS_X, 16'($urandom_range(400)) - 16'd200);
            write_reg(cmpf_pkg::CFG_ABIAS_Y, 16'($urandom_range(400)) - 16'd200);
            write_reg(cmpf_pkg::CFG_ABIAS_Z, 16'($urandom_range(400)) - 16'd200);
            write_reg(cmpf_pkg::CFG_GBIAS_X, 16'($urandom_range(400)) - 16'd200);
            write_reg(cmpf_pkg::CFG_GBIAS_Y, 16'($urandom_range(400)) - 16'd200);
            write_reg(cmpf_pkg::CFG_COUNTS, 16'($urandom_range(1, 65535)));
            send_idle_pct = idle_set[ph][0];
            stall_pct = idle_set[ph][1];
            for (int i = 0; i < 150; i++)
                send_sample(random_sample());
            wait_idle();
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    // Stall the result side at the current rate
    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (angle_queue.size() == 0)
            begin
                $display("%0t: result beat with none expected, got %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                if (out_data.roll_angle !== angle_queue[0].roll_angle)
                begin
                    $display("%0t: roll expected %0d actual %0d", $time,
                             angle_queue[0].roll_angle, out_data.roll_angle);
                    fail_count++;
                end
                if (out_data.pitch_angle !== angle_queue[0].pitch_angle)
                begin
                    $display("%0t: pitch expected %0d actual %0d", $time,
                             angle_queue[0].pitch_angle, out_data.pitch_angle);
                    fail_count++;
                end
                if (out_data.tilt_angle !== angle_queue[0].tilt_angle)
                begin
                    $display("%0t: tilt expected %0d actual %0d", $time,
                             angle_queue[0].tilt_angle, out_data.tilt_angle);
                    fail_count++;
                end
                void'(angle_queue.pop_front());
                beats_checked++;
            end
        end
    end

    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = cmpf_pkg::CFG_ALPHA;
        cfg_data = '0;
        fail_count = 0;
        beats_checked = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        p_alpha = cmpf_pkg::ALPHA_RESET;
        p_abx = 0;
        p_aby = 0;
        p_abz = 0;
        p_gbx = 0;
        p_gby = 0;
        p_counts = cmpf_pkg::COUNTS_RESET;
        est_roll = 0;
        est_pitch = 0;
        est_tilt = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_register_extremes();
        test_random_phases();
        wait_idle();
        if (angle_queue.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, angle_queue.size());
            fail_count++;
        end

        $display("Checked %0d angle beats: edge samples, register extremes, four idling phases.",
                 beats_checked);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
